// ===== hdl/imf3d_pkg.sv =====
// ----------------------------------------------------------------------------
// imf3d_pkg
// Shared constants, types and helper functions for the 3D Ising flip block.
// ----------------------------------------------------------------------------
package imf3d_pkg;

  // Lattice dimensions.
  localparam int SIZE_X = 16;
  localparam int SIZE_Y = 16;
  localparam int SIZE_Z = 16;

  // Reduced coordinate widths.
  localparam int X_AW = $clog2(SIZE_X);
  localparam int Y_AW = $clog2(SIZE_Y);
  localparam int Z_AW = $clog2(SIZE_Z);

  // The store holds one x-row of spins per word.
  localparam int ROWS       = SIZE_Y * SIZE_Z;
  localparam int ROW_AW     = $clog2(ROWS);
  localparam int SITE_COUNT = SIZE_X * SIZE_Y * SIZE_Z;

  // Field widths.
  localparam int REQ_W     = 2;
  localparam int POS_W     = 4;
  localparam int RAND_W    = 16;
  localparam int THR_W     = 16;
  localparam int DE_W      = 5;
  localparam int MAG_W     = 14;
  localparam int CFG_IDX_W = 2;
  localparam int POS_VALS  = 2 ** POS_W;

  localparam logic signed [MAG_W-1:0] MAG_RESET = MAG_W'(SITE_COUNT);

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FLIP  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  // Configuration register indices.
  localparam logic [CFG_IDX_W-1:0] CFG_THR_4  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_8  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_12 = 2'd2;

  // Builds a lookup table of v mod size for every coordinate code.
  function automatic logic [POS_VALS-1:0][7:0] mod_table(int size);
    logic [POS_VALS-1:0][7:0] t;
    int r;
    for (int i = 0; i < POS_VALS; i++) begin
      r = i;
      while (r >= size) r = r - size;
      t[i] = 8'(r);
    end
    return t;
  endfunction

  localparam logic [POS_VALS-1:0][7:0] X_MOD = mod_table(SIZE_X);
  localparam logic [POS_VALS-1:0][7:0] Y_MOD = mod_table(SIZE_Y);
  localparam logic [POS_VALS-1:0][7:0] Z_MOD = mod_table(SIZE_Z);

  // Periodic neighbour coordinates.
  function automatic logic [7:0] inc_wrap(logic [7:0] v, int size);
    return (v == 8'(size - 1)) ? 8'd0 : v + 8'd1;
  endfunction

  function automatic logic [7:0] dec_wrap(logic [7:0] v, int size);
    return (v == 8'd0) ? 8'(size - 1) : v - 8'd1;
  endfunction

  // Row address of the (y, z) line of spins.
  function automatic logic [ROW_AW-1:0] row_addr(logic [Y_AW-1:0] y, logic [Z_AW-1:0] z);
    return ROW_AW'(z) * ROW_AW'(SIZE_Y) + ROW_AW'(y);
  endfunction

  // Rows read for one request.
  typedef struct packed {
    logic [SIZE_X-1:0] center;
    logic [SIZE_X-1:0] yp;
    logic [SIZE_X-1:0] ym;
    logic [SIZE_X-1:0] zp;
    logic [SIZE_X-1:0] zm;
  } rows_t;

  // Request context presented to the evaluator.
  typedef struct packed {
    logic [REQ_W-1:0]        req_type;
    logic [X_AW-1:0]         x;
    logic                    spin_in;
    logic [RAND_W-1:0]       rand_val;
    logic [THR_W-1:0]        thr_4;
    logic [THR_W-1:0]        thr_8;
    logic [THR_W-1:0]        thr_12;
    logic signed [MAG_W-1:0] mag;
  } eval_in_t;

  // Evaluator result.
  typedef struct packed {
    logic                    spin;
    logic                    accepted;
    logic signed [DE_W-1:0]  de;
    logic signed [MAG_W-1:0] mag;
    logic [SIZE_X-1:0]       row;
  } eval_out_t;

endpackage

// ===== hdl/imf3d_if.sv =====
// ----------------------------------------------------------------------------
// imf3d_if
// Request and response channels of the 3D Ising flip block.
// ----------------------------------------------------------------------------
interface imf3d_req_if;
  logic                          valid;
  logic                          ready;
  logic [imf3d_pkg::REQ_W-1:0]   req_type;
  logic [imf3d_pkg::POS_W-1:0]   pos_x;
  logic [imf3d_pkg::POS_W-1:0]   pos_y;
  logic [imf3d_pkg::POS_W-1:0]   pos_z;
  logic                          spin_in;
  logic [imf3d_pkg::RAND_W-1:0]  rand_val;

  modport source (output valid, req_type, pos_x, pos_y, pos_z, spin_in, rand_val,
                  input ready);
  modport sink   (input valid, req_type, pos_x, pos_y, pos_z, spin_in, rand_val,
                  output ready);
endinterface

interface imf3d_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                spin_out;
  logic                                accepted;
  logic signed [imf3d_pkg::DE_W-1:0]   energy_change;
  logic signed [imf3d_pkg::MAG_W-1:0]  magnetisation;

  modport source (output valid, spin_out, accepted, energy_change, magnetisation,
                  input ready);
  modport sink   (input valid, spin_out, accepted, energy_change, magnetisation,
                  output ready);
endinterface

// ===== hdl/imf3d_row_ram.sv =====
// ----------------------------------------------------------------------------
// imf3d_row_ram
// Synchronous RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module imf3d_row_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read ports hold their data until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== hdl/imf3d_site_eval.sv =====
// ----------------------------------------------------------------------------
// imf3d_site_eval
// Energy change, Metropolis decision and row update for one request.
// ----------------------------------------------------------------------------
module imf3d_site_eval (
  input  imf3d_pkg::eval_in_t  ctrl,
  input  imf3d_pkg::rows_t     rows,
  output imf3d_pkg::eval_out_t res
);
  import imf3d_pkg::*;

  logic [X_AW-1:0]         xp;
  logic [X_AW-1:0]         xm;
  logic                    s;
  logic [5:0]              nb;
  logic [2:0]              n_up;
  logic signed [5:0]       t;
  logic signed [5:0]       de6;
  logic                    is_flip;
  logic [THR_W-1:0]        thr;
  logic                    acc;
  logic                    new_spin;
  logic [SIZE_X-1:0]       row;
  logic signed [MAG_W-1:0] mag;

  // Neighbour spins: two from the centre row, four from the other rows.
  always_comb begin
    xp = X_AW'(inc_wrap(8'(ctrl.x), SIZE_X));
    xm = X_AW'(dec_wrap(8'(ctrl.x), SIZE_X));
    s  = rows.center[ctrl.x];
    nb = {rows.center[xp], rows.center[xm], rows.yp[ctrl.x], rows.ym[ctrl.x],
          rows.zp[ctrl.x], rows.zm[ctrl.x]};
    n_up = 3'($countones(nb));
  end

  // dE = 2*s*(2n - 6), that is 4n - 12 for an up spin and its negation otherwise.
  always_comb begin
    is_flip = (ctrl.req_type == REQ_FLIP);
    t   = $signed({1'b0, n_up, 2'b00}) - 6'sd12;
    de6 = s ? t : (6'sd0 - t);
    case (de6)
      6'sd4:   thr = ctrl.thr_4;
      6'sd8:   thr = ctrl.thr_8;
      default: thr = ctrl.thr_12;
    endcase
    acc = is_flip && ((de6 <= 6'sd0) || (ctrl.rand_val <= thr));
  end

  // New spin, updated row and magnetisation.
  always_comb begin
    if (ctrl.req_type == REQ_WRITE) begin
      new_spin = ctrl.spin_in;
    end else if (acc) begin
      new_spin = ~s;
    end else begin
      new_spin = s;
    end
    row = rows.center;
    row[ctrl.x] = new_spin;
    if (new_spin != s) begin
      mag = new_spin ? ctrl.mag + 14'sd2 : ctrl.mag - 14'sd2;
    end else begin
      mag = ctrl.mag;
    end
  end

  assign res.spin     = new_spin;
  assign res.accepted = acc;
  assign res.de       = is_flip ? de6[DE_W-1:0] : '0;
  assign res.mag      = mag;
  assign res.row      = row;

endmodule

// ===== hdl/ising_metropolis_flip_3d.sv =====
// ----------------------------------------------------------------------------
// ising_metropolis_flip_3d
// 3D periodic Ising lattice with single-site Metropolis updates.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive as words on the req channel (write, flip attempt or read
//   of one site); each gives exactly one word on the rsp channel carrying the
//   site spin, the accept flag, dE and the net magnetisation after it.
//   Thresholds for dE of 4, 8 and 12 are written through cfg_we/cfg_index/
//   cfg_data; the user must write them only while the block is idle, as the
//   block itself does not enforce this.
//   The lattice is held as x-rows, one row per word, in three identical
//   copies of a two-read-port RAM, so the five rows a flip needs are read
//   together. The accept cycle issues the reads; the evaluate state then
//   evaluates, writes the row back and loads the response register, waiting
//   while the output register holds a response the receiver has not taken.
//   A new request is taken only once the previous one has left evaluation.
//   After reset a clearing pass sets every spin to +1, one row a cycle, over
//   all 256 rows (SIZE_Y * SIZE_Z); no request is taken meanwhile.
//   When the receiver stalls, one response waits in the output register and
//   one further request may be accepted and held in the evaluate stage.
// ----------------------------------------------------------------------------
module ising_metropolis_flip_3d (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [imf3d_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [imf3d_pkg::THR_W-1:0]       cfg_data,
  imf3d_req_if.sink                         req,
  imf3d_rsp_if.source                       rsp
);
  import imf3d_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0]              state;
  logic [1:0]              state_next;
  logic [ROW_AW-1:0]       clr_cnt;
  logic [THR_W-1:0]        thr_4;
  logic [THR_W-1:0]        thr_8;
  logic [THR_W-1:0]        thr_12;
  logic signed [MAG_W-1:0] mag;

  logic [REQ_W-1:0]        st_req;
  logic [X_AW-1:0]         st_x;
  logic                    st_spin_in;
  logic [RAND_W-1:0]       st_rand;
  logic [ROW_AW-1:0]       st_row;

  logic                    out_valid;
  logic                    out_spin;
  logic                    out_acc;
  logic signed [DE_W-1:0]  out_de;
  logic signed [MAG_W-1:0] out_mag;

  logic                    accept;
  logic                    exec_fire;
  logic [X_AW-1:0]         cx;
  logic [Y_AW-1:0]         cy;
  logic [Z_AW-1:0]         cz;
  logic [Y_AW-1:0]         cyp;
  logic [Y_AW-1:0]         cym;
  logic [Z_AW-1:0]         czp;
  logic [Z_AW-1:0]         czm;
  logic [ROW_AW-1:0]       ra_center;
  logic [ROW_AW-1:0]       ra_yp;
  logic [ROW_AW-1:0]       ra_ym;
  logic [ROW_AW-1:0]       ra_zp;
  logic [ROW_AW-1:0]       ra_zm;
  logic                    ram_we;
  logic [ROW_AW-1:0]       ram_waddr;
  logic [SIZE_X-1:0]       ram_wdata;
  logic [SIZE_X-1:0]       spare_row;
  rows_t                   rows;
  eval_in_t                ev_in;
  eval_out_t               ev_out;

  // Handshake control.
  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign exec_fire = (state == ST_EXEC) && (!out_valid || rsp.ready);

  // Coordinates reduced to the lattice and their periodic neighbours.
  always_comb begin
    cx  = X_MOD[req.pos_x][X_AW-1:0];
    cy  = Y_MOD[req.pos_y][Y_AW-1:0];
    cz  = Z_MOD[req.pos_z][Z_AW-1:0];
    cyp = Y_AW'(inc_wrap(8'(cy), SIZE_Y));
    cym = Y_AW'(dec_wrap(8'(cy), SIZE_Y));
    czp = Z_AW'(inc_wrap(8'(cz), SIZE_Z));
    czm = Z_AW'(dec_wrap(8'(cz), SIZE_Z));
    ra_center = row_addr(cy, cz);
    ra_yp     = row_addr(cyp, cz);
    ra_ym     = row_addr(cym, cz);
    ra_zp     = row_addr(cy, czp);
    ra_zm     = row_addr(cy, czm);
  end

  // Sequencer: clearing pass, idle, evaluate.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_cnt == ROW_AW'(ROWS - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (accept) state_next = ST_EXEC;
      ST_EXEC:  if (exec_fire) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      thr_4  <= '0;
      thr_8  <= '0;
      thr_12 <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THR_4:  thr_4  <= cfg_data;
        CFG_THR_8:  thr_8  <= cfg_data;
        CFG_THR_12: thr_12 <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Request context held for the evaluate cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      st_req     <= req.req_type;
      st_x       <= cx;
      st_spin_in <= req.spin_in;
      st_rand    <= req.rand_val;
      st_row     <= ra_center;
    end
  end

  // Row store write port: clearing pass or write-back.
  always_comb begin
    ram_we    = (state == ST_CLEAR) || exec_fire;
    ram_waddr = (state == ST_CLEAR) ? clr_cnt : st_row;
    ram_wdata = (state == ST_CLEAR) ? '1 : ev_out.row;
  end

  // Three copies of the row store give five row reads together.
  imf3d_row_ram #(.DEPTH(ROWS), .WIDTH(SIZE_X)) u_ram0 (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (accept),
    .raddr_a (ra_center),
    .raddr_b (ra_yp),
    .rdata_a (rows.center),
    .rdata_b (rows.yp)
  );

  imf3d_row_ram #(.DEPTH(ROWS), .WIDTH(SIZE_X)) u_ram1 (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (accept),
    .raddr_a (ra_ym),
    .raddr_b (ra_zp),
    .rdata_a (rows.ym),
    .rdata_b (rows.zp)
  );

  imf3d_row_ram #(.DEPTH(ROWS), .WIDTH(SIZE_X)) u_ram2 (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (accept),
    .raddr_a (ra_zm),
    .raddr_b (ra_center),
    .rdata_a (rows.zm),
    .rdata_b (spare_row)
  );

  // Evaluation of the site.
  always_comb begin
    ev_in.req_type = st_req;
    ev_in.x        = st_x;
    ev_in.spin_in  = st_spin_in;
    ev_in.rand_val = st_rand;
    ev_in.thr_4    = thr_4;
    ev_in.thr_8    = thr_8;
    ev_in.thr_12   = thr_12;
    ev_in.mag      = mag;
  end

  imf3d_site_eval u_eval (
    .ctrl (ev_in),
    .rows (rows),
    .res  (ev_out)
  );

  // Magnetisation register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mag <= MAG_RESET;
    end else if (exec_fire) begin
      mag <= ev_out.mag;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_spin <= ev_out.spin;
      out_acc  <= ev_out.accepted;
      out_de   <= ev_out.de;
      out_mag  <= ev_out.mag;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.spin_out      = out_spin;
  assign rsp.accepted      = out_acc;
  assign rsp.energy_change = out_de;
  assign rsp.magnetisation = out_mag;

  // The unused read port of the third copy mirrors the centre row.
  a_spare_row: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |-> (spare_row == rows.center))
    else $error("spare read port disagrees with centre row");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_EXEC))
    else $error("accepted request did not enter evaluation");

  a_no_rsp_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !out_valid)
    else $error("response valid during clearing pass");

  a_flip_moves_mag: assert property (@(posedge clk) disable iff (rst)
    (exec_fire && ev_out.accepted) |=> (mag != $past(mag)))
    else $error("accepted flip left magnetisation unchanged");

  a_mag_parity: assert property (@(posedge clk) disable iff (rst)
    mag[0] == MAG_RESET[0])
    else $error("magnetisation parity broken");

endmodule
